/* src/pli_pkg.sv */
// Package for the piecewise linear interpolator: codes, widths, shared types.
// No dependencies.
package pli_pkg;
	localparam int DefaultMaxNodes = 64;
	localparam int ValW = 32;
	localparam int MagW = 33;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_EVAL = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_RANGE = 2'd1,
		ST_NOT_INC = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAST_RD,
		S_LAST_CHK,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_HIT_RD,
		S_HIT_CHK,
		S_PAIR_RD,
		S_PAIR_LO,
		S_MUL,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;
endpackage

/* src/pli_node_mem.sv */
// Node storage: x and y memories, one write port, one registered read port.
// Depends on pli_pkg.
module pli_node_mem #(
	parameter int MAX_NODES = pli_pkg::DefaultMaxNodes,
	parameter int AW = $clog2(MAX_NODES)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic signed [pli_pkg::ValW-1:0] wx,
	input  logic signed [pli_pkg::ValW-1:0] wy,
	input  logic [AW-1:0]                raddr,
	output logic signed [pli_pkg::ValW-1:0] rx,
	output logic signed [pli_pkg::ValW-1:0] ry
);
	import pli_pkg::*;
	logic signed [ValW-1:0] xmem [MAX_NODES];
	logic signed [ValW-1:0] ymem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			xmem[waddr] <= wx;
			ymem[waddr] <= wy;
		end
		rx <= xmem[raddr];
		ry <= ymem[raddr];
	end
endmodule

/* src/pli_divider.sv */
// Restoring serial divider, one quotient bit per cycle, 64-bit by 33-bit.
// Depends on pli_pkg.
module pli_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [pli_pkg::MagW-1:0] den,
	output logic        done,
	output logic [63:0] quo
);
	import pli_pkg::*;
	logic [MagW-1:0] rem_q;
	logic [MagW-1:0] den_q;
	logic [63:0] quo_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [MagW:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	assign quo = quo_q;
	assign done = busy_q && (cnt_q == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 7'd64;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q && cnt_q != 7'd0) begin
			if (!trial[MagW]) begin
				rem_q <= trial[MagW-1:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[MagW-2:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

/* src/piecewise_linear_interpolator_core.sv */
// Top level of the piecewise linear interpolator.
// Depends on pli_pkg, pli_node_mem, pli_divider.
//
// Use: one request channel (action, x_value, y_value) and one result channel
// (y_result, status, nodes_held), both valid/stall. Every request yields
// exactly one result. Nodes sit in a 64-entry x/y memory pair with a
// registered read; appends must have strictly increasing x.
// Path to the result: clear, no-op, full-table append, first append and
// empty-table evaluate go straight to the result state; other appends first
// pass S_LAST_RD and S_LAST_CHK (they read the last node to check order).
// An evaluate does a binary search over the node memory, a read state and a
// check state per probe, then reads the bracketing pair, multiplies |dy| by
// (q-x0) in the cycle the divider loads, and runs a serial divide.
// One request at a time; a new request is taken only in the idle cycle after
// the result leaves.
// Reset clears the node count and control state; memory contents are not
// cleared, as only entries below the count ever affect a result.
// While out_stall is high the result holds and no new request is taken.
module piecewise_linear_interpolator_core #(
	parameter int MAX_NODES = pli_pkg::DefaultMaxNodes
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] action,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] y_result,
	output logic [1:0] status,
	output logic [$clog2(MAX_NODES+1)-1:0] nodes_held
);
	import pli_pkg::*;
	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES+1);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic signed [31:0] q_q, ynew_q;
	logic [CW-1:0] lo_q, hi_q, mid;   // search range [lo,hi)
	logic signed [31:0] x0_q, y0_q, x1_q, y1_q;
	logic [63:0] prod;
	logic neg_q;
	logic [AW-1:0] raddr;
	logic signed [31:0] rx, ry;
	logic signed [31:0] wx, wy;
	logic we;
	logic div_start, div_done;
	logic [63:0] quo;
	logic accept;
	logic signed [32:0] dy, dx, dq;
	logic [32:0] mag;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign nodes_held = cnt_q;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign dy = {y1_q[31], y1_q} - {y0_q[31], y0_q};
	assign dx = {x1_q[31], x1_q} - {x0_q[31], x0_q};
	assign dq = {q_q[31], q_q} - {x0_q[31], x0_q};
	assign mag = dy[32] ? 33'(-dy) : 33'(dy);
	// product feeds the divider load directly
	assign prod = 64'(mag) * 64'(33'(dq));
	// first append writes straight from the request ports
	assign wx = (state_q == S_IDLE) ? x_value : q_q;
	assign wy = (state_q == S_IDLE) ? y_value : ynew_q;

	pli_node_mem #(.MAX_NODES(MAX_NODES), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(cnt_q[AW-1:0]), .wx(wx), .wy(wy),
		.raddr(raddr), .rx(rx), .ry(ry));

	pli_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(prod),
		.den(33'(dx)), .done(div_done), .quo(quo));

	always_comb begin
		raddr = mid[AW-1:0];
		case (state_q)
			S_LAST_RD: raddr = AW'(cnt_q - CW'(1));
			S_HIT_RD:  raddr = lo_q[AW-1:0];
			S_PAIR_RD: raddr = AW'(lo_q - CW'(1));
			default:   raddr = mid[AW-1:0];
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action_t'(action))
						ACT_APPEND: state_d = (cnt_q >= CW'(MAX_NODES)) ? S_OUT :
							(cnt_q == '0) ? S_OUT : S_LAST_RD;
						ACT_EVAL: state_d = (cnt_q == '0) ? S_OUT : S_SRCH_RD;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_LAST_RD:  state_d = S_LAST_CHK;
			S_LAST_CHK: state_d = S_OUT;
			S_SRCH_RD:  state_d = S_SRCH_CHK;
			S_SRCH_CHK: state_d = (lo_q == hi_q) ? S_HIT_RD : S_SRCH_RD;
			S_HIT_RD:   state_d = S_HIT_CHK;
			S_HIT_CHK: begin
				if (lo_q == cnt_q || rx == q_q || lo_q == '0) state_d = S_OUT;
				else state_d = S_PAIR_RD;
			end
			S_PAIR_RD:  state_d = S_PAIR_LO;
			S_PAIR_LO:  state_d = S_MUL;
			S_MUL:      state_d = S_DIV;
			S_DIV:      state_d = div_done ? S_FIN : S_DIV;
			S_FIN:      state_d = S_OUT;
			S_OUT:      state_d = out_stall ? S_OUT : S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		out_valid = (state_q == S_OUT);
		div_start = (state_q == S_MUL);
		we = (state_q == S_IDLE && accept && action_t'(action) == ACT_APPEND &&
			cnt_q == '0) || (state_q == S_LAST_CHK && cnt_q < CW'(MAX_NODES) && q_q > rx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && accept && action_t'(action) == ACT_CLEAR)
				cnt_q <= '0;
			else if (we)
				cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q <= x_value;
				ynew_q <= y_value;
				lo_q <= '0;
				hi_q <= cnt_q;
				y_result <= '0;
				status <= ST_OK;
				if (action_t'(action) == ACT_APPEND && cnt_q >= CW'(MAX_NODES))
					status <= ST_FULL;
				if (action_t'(action) == ACT_EVAL && cnt_q == '0)
					status <= ST_RANGE;
			end
			S_LAST_CHK: if (!(q_q > rx)) status <= ST_NOT_INC;
			S_SRCH_CHK: begin
				// lower bound: first node with x >= q
				if (lo_q != hi_q) begin
					if (rx < q_q) lo_q <= mid + CW'(1);
					else hi_q <= mid;
				end
			end
			S_HIT_CHK: begin
				x1_q <= rx;
				y1_q <= ry;
				if (lo_q == cnt_q || (lo_q == '0 && rx != q_q)) status <= ST_RANGE;
				else if (rx == q_q) y_result <= ry;
			end
			S_PAIR_LO: begin
				x0_q <= rx;
				y0_q <= ry;
			end
			S_MUL: neg_q <= dy[32];
			S_FIN: y_result <= neg_q ? 32'(y0_q - 32'(quo)) : 32'(y0_q + 32'(quo));
			default: ;
		endcase
	end
endmodule
